// ===== src/gmpe_pkg.sv =====
// Shared constants, widths and the exponential step table for the mixture density evaluator.
package gmpe_pkg;

  localparam int SAMPLE_W       = 24;
  localparam int DENS_W         = 32;
  localparam int REG_W          = 64;
  localparam int NUM_REGS       = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int COMPONENTS_DEF = 3;

  localparam int W_W  = 16;
  localparam int S_W  = 24;
  localparam int AD_W = 25;
  localparam int D2_W = 50;
  localparam int S2_W = 48;
  localparam int K_W  = 31;
  localparam int WK_W = 47;
  localparam int SD_W = 31;
  localparam int TR_W = 64;
  localparam int DW_W = 72;

  localparam logic [K_W-1:0] INV_SQRT_2PI = 31'd1713444049;

  // Quotient bits of the exponent argument and of the amplitude.
  localparam int TQ        = 21;
  localparam int AQ        = 40;
  localparam int EXP_STEPS = 13;
  localparam int E_W       = 33;
  localparam int CONTRIB_W = 41;
  localparam int LANE_LAT  = 45;

  // exp(-2^(k-8)) in Q0.32.
  function automatic logic [31:0] exp_step(input logic [3:0] k);
    logic [31:0] v;
    case (k)
      4'd0:    v = 32'd4278222805;
      4'd1:    v = 32'd4261543595;
      4'd2:    v = 32'd4228380000;
      4'd3:    v = 32'd4162825044;
      4'd4:    v = 32'd4034748382;
      4'd5:    v = 32'd3790295335;
      4'd6:    v = 32'd3344923893;
      4'd7:    v = 32'd2605029347;
      4'd8:    v = 32'd1580030169;
      4'd9:    v = 32'd581260616;
      4'd10:   v = 32'd78665070;
      4'd11:   v = 32'd1440801;
      4'd12:   v = 32'd483;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/gaussian_mixture_pdf_eval.sv =====
// An accepted sample passes through the component lanes, the sum register and the output register.
// Throughput: one sample per cycle while output is drained; all stages share one enable.
// The depth is set by the 40-stage amplitude divider in each component lane.
// Reset clears valid bits and the component registers; payload registers are not reset.
// Input is taken while a result waits as long as the output register is being drained.
module gaussian_mixture_pdf_eval import gmpe_pkg::*; #(
  parameter int COMPONENTS = COMPONENTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // [23:0] sample
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [55:0]          m_axis_tdata,   // [23:0] position, [55:24] density
  output logic                 m_axis_tuser,   // [0] saturated
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  localparam int SUM_W = CONTRIB_W + $clog2(COMPONENTS) + 1;

  logic                 en;
  logic [REG_W-1:0]     comp_q   [COMPONENTS];
  logic [CONTRIB_W-1:0] contrib  [COMPONENTS];
  logic                 vld_q    [0:LANE_LAT-1];
  logic [SAMPLE_W-1:0]  pos_q    [0:LANE_LAT-1];
  logic [SUM_W-1:0]     sum_d, sum_q;
  logic                 vs_q;
  logic [SAMPLE_W-1:0]  poss_q;
  logic                 out_vld_q;
  logic [SAMPLE_W-1:0]  out_pos_q;
  logic [DENS_W-1:0]    out_dens_q;
  logic                 out_sat_q;
  logic                 sat;

  assign en            = m_axis_tready || !out_vld_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COMPONENTS; i++) comp_q[i] <= '0;
    end else begin
      for (int i = 0; i < COMPONENTS; i++) begin
        if (cfg_we_i && i < NUM_REGS && cfg_index_i == CFG_IDX_W'(i)) begin
          comp_q[i] <= cfg_data_i;
        end
      end
    end
  end

  for (genvar g = 0; g < COMPONENTS; g++) begin : g_lane
    gmpe_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .sample_i (s_axis_tdata),
      .comp_i   (comp_q[g]),
      .contrib_o(contrib[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_LAT; i++) vld_q[i] <= 1'b0;
      vs_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < LANE_LAT; i++) vld_q[i] <= vld_q[i-1];
      vs_q      <= vld_q[LANE_LAT-1];
      out_vld_q <= vs_q;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < COMPONENTS; i++) sum_d = sum_d + SUM_W'(contrib[i]);
  end

  assign sat = |sum_q[SUM_W-1:DENS_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q[0] <= s_axis_tdata;
      for (int i = 1; i < LANE_LAT; i++) pos_q[i] <= pos_q[i-1];
      sum_q      <= sum_d;
      poss_q     <= pos_q[LANE_LAT-1];
      out_pos_q  <= poss_q;
      out_dens_q <= sat ? '1 : sum_q[DENS_W-1:0];
      out_sat_q  <= sat;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_dens_q, out_pos_q};
  assign m_axis_tuser  = out_sat_q;

`ifndef ASSERT_OFF
  a_sat_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[55:24] == '1)
    else $error("saturated result without clamped density");

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (m_axis_tready || !m_axis_tvalid))
    else $error("input ready disagrees with output drain state");

  a_stall_holds_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(sum_q) && $stable(vs_q))
    else $error("sum stage moved during a stall");
`endif

endmodule

// ===== src/gmpe_lane.sv =====
// One mixture component: pipelined distance, two restoring dividers, exponential and scaling.
module gmpe_lane import gmpe_pkg::*; (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [REG_W-1:0]           comp_i,
  output logic [CONTRIB_W-1:0]       contrib_o
);

  localparam int PAD   = AQ - TQ - 1 - EXP_STEPS;
  localparam int E_LEN = EXP_STEPS + PAD;

  logic signed [AD_W-1:0] diff;
  logic [AD_W-1:0]        ad_d;
  logic [AD_W-1:0]        ad_q;
  logic [S_W-1:0]         s1_q;
  logic [W_W-1:0]         w1_q;
  logic                   kill1_q;

  logic [D2_W-1:0] d2_q;
  logic [S2_W-1:0] s2_q;
  logic [WK_W-1:0] wk_q;
  logic [SD_W-1:0] sd2_q;
  logic            kill2_q;

  logic [WK_W-1:0] ar_q  [0:AQ];
  logic [AQ-1:0]   aq_q  [0:AQ];
  logic [SD_W-1:0] ad2_q [0:AQ];
  logic            kill_q[0:AQ];

  logic [TR_W-1:0] tr_q  [0:TQ];
  logic [TQ-1:0]   tq_q  [0:TQ];
  logic [S2_W-1:0] ts2_q [0:TQ];

  logic [E_W-1:0]  e_q   [0:E_LEN];
  logic [TQ-1:0]   tt_q  [0:E_LEN];

  logic [64:0]     plo_q;
  logic [40:0]     phi_q;
  logic            killp_q;
  logic [CONTRIB_W-1:0] contrib_q;

  logic tail;

  assign diff = {sample_i[SAMPLE_W-1], sample_i}
              - {comp_i[47], comp_i[47:24]};
  assign ad_d = diff[AD_W-1] ? AD_W'(-diff) : AD_W'(diff);
  assign tail = {3'b000, d2_q} > {s2_q, 5'b00000};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ad_q    <= ad_d;
      s1_q    <= comp_i[S_W-1:0];
      w1_q    <= comp_i[63:48];
      kill1_q <= (comp_i[S_W-1:0] == '0) || (comp_i[63:48] == '0);

      d2_q    <= D2_W'(ad_q * ad_q);
      s2_q    <= S2_W'(s1_q * s1_q);
      wk_q    <= WK_W'(w1_q * INV_SQRT_2PI);
      sd2_q   <= {s1_q, 7'b0000000};
      kill2_q <= kill1_q;

      ar_q[0]   <= wk_q;
      aq_q[0]   <= '0;
      ad2_q[0]  <= sd2_q;
      kill_q[0] <= kill2_q || tail;
      tr_q[0]   <= {d2_q[48:0], 15'b0};
      tq_q[0]   <= '0;
      ts2_q[0]  <= s2_q;

      // Amplitude divider: one quotient bit per stage, highest first.
      for (int i = 0; i < AQ; i++) begin
        logic [DW_W-1:0] cand;
        cand = DW_W'(ad2_q[i]) << (AQ - 1 - i);
        if (DW_W'(ar_q[i]) >= cand) begin
          ar_q[i+1] <= ar_q[i] - cand[WK_W-1:0];
          aq_q[i+1] <= aq_q[i] | (AQ'(1) << (AQ - 1 - i));
        end else begin
          ar_q[i+1] <= ar_q[i];
          aq_q[i+1] <= aq_q[i];
        end
        ad2_q[i+1]  <= ad2_q[i];
        kill_q[i+1] <= kill_q[i];
      end

      // Exponent argument divider, d^2 * 2^15 / sigma^2.
      for (int j = 0; j < TQ; j++) begin
        logic [DW_W-1:0] cand;
        cand = DW_W'(ts2_q[j]) << (TQ - 1 - j);
        if (DW_W'(tr_q[j]) >= cand) begin
          tr_q[j+1] <= tr_q[j] - cand[TR_W-1:0];
          tq_q[j+1] <= tq_q[j] | (TQ'(1) << (TQ - 1 - j));
        end else begin
          tr_q[j+1] <= tr_q[j];
          tq_q[j+1] <= tq_q[j];
        end
        ts2_q[j+1] <= ts2_q[j];
      end

      // Linear start for the low byte, then one table factor per set bit.
      e_q[0]  <= E_W'(34'h1_0000_0000 - {10'b0, tq_q[TQ][7:0], 16'b0});
      tt_q[0] <= tq_q[TQ];
      for (int k = 0; k < EXP_STEPS; k++) begin
        logic [64:0] prod;
        prod = 65'(e_q[k] * exp_step(4'(k)));
        if (tt_q[k][8+k]) begin
          e_q[k+1] <= prod[64:32];
        end else begin
          e_q[k+1] <= e_q[k];
        end
        tt_q[k+1] <= tt_q[k];
      end
      // Delay stages that line the exponential up with the amplitude divider.
      for (int k = EXP_STEPS; k < E_LEN; k++) begin
        e_q[k+1]  <= e_q[k];
        tt_q[k+1] <= tt_q[k];
      end

      plo_q   <= 65'(aq_q[AQ][31:0] * e_q[E_LEN]);
      phi_q   <= 41'(aq_q[AQ][AQ-1:32] * e_q[E_LEN]);
      killp_q <= kill_q[AQ];

      contrib_q <= killp_q ? '0 : CONTRIB_W'(phi_q + {8'b0, plo_q[64:32]});
    end
  end

  assign contrib_o = contrib_q;

endmodule

// ===== dv/gaussian_mixture_pdf_eval_tb.sv =====
// Self-checking testbench for the Gaussian mixture density evaluator.
module gaussian_mixture_pdf_eval_tb import gmpe_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_WAIT     = 60;
  localparam int PHASE_ITEMS    = 180;
  localparam logic [CFG_IDX_W-1:0] IDX_COMP0  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_COMP1  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_COMP2  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = 2'd3;

  typedef struct packed {
    logic [23:0] position;
    logic [31:0] density;
    logic        saturated;
  } density_t;

  class density_board;
    logic [63:0] comp_q[NUM_REGS];
    density_t    pending_q[$];
    int          errors;
    int          checked;
    int          saturations;
    // exp(-2^(k-8)) in Q0.32, applied for each set bit 8..20 of the exponent argument.
    bit   [63:0] exp_tab[EXP_STEPS] = '{64'd4278222805, 64'd4261543595, 64'd4228380000,
                                       64'd4162825044, 64'd4034748382, 64'd3790295335,
                                       64'd3344923893, 64'd2605029347, 64'd1580030169,
                                       64'd581260616, 64'd78665070, 64'd1440801, 64'd483};

    function new();
      foreach (comp_q[i]) comp_q[i] = '0;
      errors = 0;
      checked = 0;
      saturations = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
      if (idx < NUM_REGS) comp_q[idx] = val;
    endfunction

    function bit [63:0] component_density(logic [63:0] r, logic [23:0] x);
      bit [63:0] w, s, ad, d2, s2, ip, rem, t, e, amp;
      longint    d;
      w = {48'd0, r[63:48]};
      s = {40'd0, r[23:0]};
      if (s == 0 || w == 0) return 0;
      d  = longint'($signed(x)) - longint'($signed(r[47:24]));
      ad = (d < 0) ? -d : d;
      d2 = ad * ad;
      s2 = s * s;
      if (d2 > (s2 << 5)) return 0;
      ip  = d2 / s2;
      rem = d2 % s2;
      t   = (ip << 15) + ((rem << 15) / s2);
      e   = (64'd1 << 32) - ({56'd0, t[7:0]} << 16);
      for (int k = 0; k < EXP_STEPS; k++)
        if (t[8+k]) e = (e * exp_tab[k]) >> 32;
      amp = (w * 64'd1713444049) / (s << 7);
      return (amp >> 32) * e + (((amp & 64'hFFFF_FFFF) * e) >> 32);
    endfunction

    function void note_sample(logic [23:0] x);
      bit [63:0] sum;
      density_t  exp_r;
      sum = 0;
      for (int i = 0; i < COMPONENTS_DEF; i++)
        if (i < NUM_REGS) sum += component_density(comp_q[i], x);
      exp_r.position  = x;
      exp_r.saturated = (sum > 64'hFFFF_FFFF);
      exp_r.density   = exp_r.saturated ? 32'hFFFF_FFFF : sum[31:0];
      if (exp_r.saturated) saturations++;
      pending_q = {pending_q, exp_r};
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(logic [23:0] pos, logic [31:0] dens, logic sat);
      density_t e;
      checked++;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result pos=%h dens=%h", pos, dens));
        return;
      end
      e = pending_q.pop_front();
      if (pos !== e.position)
        report($sformatf("position got %h want %h", pos, e.position));
      if (dens !== e.density)
        report($sformatf("density at %h got %h want %h", e.position, dens, e.density));
      if (sat !== e.saturated)
        report($sformatf("saturated at %h got %b want %b", e.position, sat, e.saturated));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [55:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [REG_W-1:0]     cfg_data_i = '0;

  density_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  int sent = 0;

  gaussian_mixture_pdf_eval i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: a long hold-off takes priority over random stalls.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) board.note_sample(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata[23:0], m_axis_tdata[55:24], m_axis_tuser);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("** gaussian_mixture_pdf_eval: FAILED **");
      $finish;
    end
  end

  task send_sample(logic [23:0] x);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    // Valid stays high until the next call or stop_sending changes it at a falling edge.
  endtask

  task stop_sending();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task drain();
    stop_sending();
    wait (board.pending_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    board.write_reg(idx, val);
  endtask

  function automatic logic [63:0] pack_comp(logic [15:0] w, logic [23:0] mu, logic [23:0] s);
    return {w, mu, s};
  endfunction

  function automatic logic [23:0] near_mean(logic [63:0] r);
    longint span, off;
    span = longint'(r[23:0]) * 6;
    if (span > 64'h7FFFFF) span = 64'h7FFFFF;
    if (span == 0) span = 256;
    off = longint'($urandom_range(0, 2 * span)) - span;
    return 24'(longint'($signed(r[47:24])) + off);
  endfunction

  function automatic logic [63:0] random_comp();
    logic [23:0] s;
    s = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(24'h400, 24'h40000));
    return pack_comp(16'($urandom), 24'($urandom_range(0, 24'h100000)) - 24'h80000, s);
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: every component is empty, density must be zero.
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);
    send_sample(24'h000000);
    drain();

    // Unit sigma, extreme mean, zero sigma and a write to the unused index.
    write_cfg(IDX_COMP0, pack_comp(16'h8000, 24'h000000, 24'h010000));
    write_cfg(IDX_COMP1, pack_comp(16'hFFFF, 24'h7FFFFF, 24'h010000));
    write_cfg(IDX_COMP2, pack_comp(16'hFFFF, 24'h000000, 24'h000000));
    write_cfg(IDX_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(24'h000000);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h05A827);   // just inside the far-tail cutoff
    send_sample(24'h05A830);   // just beyond it
    send_sample(24'hFA57D9);
    send_sample(24'h000100);
    drain();

    // Smallest sigma with full weight overflows at its mean; a zero-weight component.
    write_cfg(IDX_COMP0, pack_comp(16'hFFFF, 24'h000000, 24'h000001));
    write_cfg(IDX_COMP1, pack_comp(16'h0000, 24'h000000, 24'h010000));
    write_cfg(IDX_COMP2, pack_comp(16'hFFFF, 24'h800000, 24'hFFFFFF));
    send_sample(24'h000000);
    send_sample(24'h000001);
    send_sample(24'h000005);
    send_sample(24'hFFFFFF);
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);
    send_sample(24'h123456);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      if (ph == 4) begin
        write_cfg(IDX_COMP0, pack_comp(16'hFFFF, 24'h000000, 24'h000010));
        write_cfg(IDX_COMP1, pack_comp(16'h0001, 24'h7FFFFF, 24'hFFFFFF));
        write_cfg(IDX_COMP2, pack_comp(16'h7FFF, 24'h800000, 24'h000100));
      end else begin
        write_cfg(IDX_COMP0, random_comp());
        write_cfg(IDX_COMP1, random_comp());
        write_cfg(IDX_COMP2, random_comp());
      end
      if (ph == 0) hold_cycles = 400;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(9) < 7)
          send_sample(near_mean(board.comp_q[$urandom_range(NUM_REGS - 1)]));
        else
          send_sample(24'($urandom));
      end
      drain();
    end
    stop_sending();
    recv_stall_pct = 0;
    wait (board.pending_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d samples over 8 traffic phases and 3 directed settings; %0d checked.",
             sent, board.checked);
    $display("%0d results were expected to saturate.", board.saturations);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("** gaussian_mixture_pdf_eval: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", board.errors, board.pending_q.size());
      $display("** gaussian_mixture_pdf_eval: FAILED **");
    end
    $finish;
  end

endmodule
